FILE: rtl/core/mstt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mstt_pkg;

    // Widths fixed by the word formats
    localparam int SLOT_W = 4;
    localparam int TIME_W = 32;

    // Input mode codes
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_CANCEL = 3'd2;
    localparam logic [2:0] MODE_UPDATE = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    // Result kind codes
    localparam logic [1:0] KIND_GRANT = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_TIME  = 2'd2;

    typedef struct packed {
        logic [2:0]        mode;
        logic [TIME_W-1:0] delay;
        logic              periodic;
        logic [SLOT_W-1:0] slot_id;
    } t_in;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic              no_free_slot;
        logic [TIME_W-1:0] time_value;
        logic              last;
    } t_out;

    // Operation carried by the token that walks the cell row
    typedef enum logic [1:0] {
        OP_START,
        OP_CANCEL,
        OP_UPDATE
    } t_op;

    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [TIME_W-1:0] delay;
        logic              periodic;
        logic [SLOT_W-1:0] sid;
    } t_tok;

    // Status a cell reports to the sequencer
    typedef struct packed {
        logic hit;
        logic tok_valid;
    } t_cell_st;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/mstt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One timer slot. Registers the token on each advance and hands it on.
module mstt_cell
    import mstt_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic [TIME_W-1:0] i_now,
    input  wire t_tok              i_tok,
    output t_tok                   o_tok,
    output t_cell_st               o_st
);

    t_tok              r_tok;
    logic              r_active;
    logic [TIME_W-1:0] r_target;
    logic [TIME_W-1:0] r_interval;
    logic              r_periodic;

    logic start_hit;
    logic upd_hit;
    logic cancel_hit;

    always_comb begin
        start_hit  = r_tok.valid && (r_tok.op == OP_START) && !r_active;
        upd_hit    = r_tok.valid && (r_tok.op == OP_UPDATE) && r_active
                     && (i_now >= r_target);
        cancel_hit = r_tok.valid && (r_tok.op == OP_CANCEL)
                     && (r_tok.sid == SLOT_W'(IDX));
        o_tok      = r_tok;
        // a granted start is consumed here
        if (start_hit) begin
            o_tok.valid = 1'b0;
        end
        o_st.hit       = start_hit || upd_hit;
        o_st.tok_valid = r_tok.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= '0;
            r_active <= 1'b0;
        end else if (i_adv) begin
            r_tok <= i_tok;
            if (start_hit) begin
                r_active <= 1'b1;
            end else if ((upd_hit && !r_periodic) || cancel_hit) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (start_hit) begin
                r_target   <= i_now + r_tok.delay;
                r_interval <= r_tok.delay;
                r_periodic <= r_tok.periodic;
            end else if (upd_hit && r_periodic) begin
                r_target <= i_now + r_interval;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/multi_slot_timeout_timer.sv
`timescale 1ns / 1ps
`default_nettype none

// Multi-slot millisecond timer.
// Input channel (i_in_valid / o_in_stall, word i_in): tick, start, cancel,
// update or read. Output channel (o_out_valid / i_out_stall, word o_out):
// start replies, fired slots and time readings, with last on the final word
// of each input word.
// A tick gives no word. A read stages its word in the pending register and
// moves it into the output register once that is free; the next input is taken
// after that move. Start, cancel and update send a token down a row of
// SLOT_COUNT cells, one cell per cycle unless the row is held; a start stops
// at the first free slot. The walk of that token through the row sets the pace:
// one input word is in work at a time.
// Reset clears the counter and frees every slot, all at once.
// While the receiver stalls, the output register holds its word; the scan holds
// only when a second result is ready, the pending register is full and the
// output register is full and stalled.
module multi_slot_timeout_timer
    import mstt_pkg::*;
#(
    parameter int SLOT_COUNT = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_now, n_now;
    t_op               r_op, n_op;
    logic              r_pend_v, n_pend_v;
    t_out              r_pend, n_pend;
    logic              r_ov, n_ov;
    t_out              r_out, n_out;

    t_tok              tok_in;
    t_tok              tok [SLOT_COUNT+1];
    t_cell_st          st  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] hit_vec;
    logic [SLOT_COUNT-1:0] tok_vec;

    logic              in_acc;
    logic              out_free;
    logic              adv;
    logic              push;
    logic              hit_any;
    logic              end_tok;
    logic [SLOT_W-1:0] hit_idx;

    assign tok[0] = tok_in;

    // Row of cells: token enters at cell zero and moves one cell per advance
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        mstt_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_now   (r_now),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .o_st    (st[g])
        );
    end

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            hit_vec[i] = st[i].hit;
            tok_vec[i] = st[i].tok_valid;
            if (st[i].hit) begin
                hit_idx = hit_idx | SLOT_W'(i);
            end
        end
        hit_any = |hit_vec;
        end_tok = tok[SLOT_COUNT].valid;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_comb begin
        n_state  = r_state;
        n_now    = r_now;
        n_op     = r_op;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        push     = 1'b0;
        adv      = 1'b0;
        tok_in   = '0;

        unique case (r_state)
            ST_IDLE: begin
                adv             = 1'b1;
                tok_in.delay    = i_in.delay;
                tok_in.periodic = i_in.periodic;
                tok_in.sid      = i_in.slot_id;
                if (in_acc) begin
                    unique case (i_in.mode)
                        MODE_TICK: begin
                            n_now = r_now + TIME_W'(1);
                        end
                        MODE_START: begin
                            tok_in.valid = 1'b1;
                            tok_in.op    = OP_START;
                            n_op         = OP_START;
                            n_state      = ST_SCAN;
                        end
                        MODE_CANCEL: begin
                            tok_in.valid = 1'b1;
                            tok_in.op    = OP_CANCEL;
                            n_op         = OP_CANCEL;
                            n_state      = ST_SCAN;
                        end
                        MODE_UPDATE: begin
                            tok_in.valid = 1'b1;
                            tok_in.op    = OP_UPDATE;
                            n_op         = OP_UPDATE;
                            n_state      = ST_SCAN;
                        end
                        MODE_READ: begin
                            n_pend_v          = 1'b1;
                            n_pend            = '0;
                            n_pend.kind       = KIND_TIME;
                            n_pend.time_value = r_now;
                            n_pend.last       = 1'b1;
                            n_state           = ST_FLUSH;
                        end
                        default: begin
                            // unused modes: drop the word
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // hold the row when a second result has nowhere to go
                adv = !(hit_any && r_pend_v && !out_free);
                if (adv) begin
                    if (hit_any) begin
                        push        = r_pend_v;
                        n_pend_v    = 1'b1;
                        n_pend      = '0;
                        n_pend.kind = (r_op == OP_START) ? KIND_GRANT : KIND_FIRED;
                        n_pend.slot = hit_idx;
                        n_pend.last = (r_op == OP_START) || end_tok;
                        if ((r_op == OP_START) || end_tok) begin
                            n_state = ST_FLUSH;
                        end
                    end else if (end_tok) begin
                        unique case (r_op)
                            OP_START: begin
                                // every slot busy
                                n_pend_v            = 1'b1;
                                n_pend              = '0;
                                n_pend.kind         = KIND_GRANT;
                                n_pend.no_free_slot = 1'b1;
                                n_pend.last         = 1'b1;
                                n_state             = ST_FLUSH;
                            end
                            OP_UPDATE: begin
                                if (r_pend_v) begin
                                    n_pend.last = 1'b1;
                                    n_state     = ST_FLUSH;
                                end else begin
                                    n_state = ST_IDLE;
                                end
                            end
                            default: begin
                                n_state = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    push     = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // output register
        n_out = r_out;
        if (push) begin
            n_ov  = 1'b1;
            n_out = r_pend;
        end else begin
            n_ov = r_ov && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_now    <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    // only one cell can claim the token
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec))
        else $error("more than one cell hit");

    // a single token in the row
    a_one_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one token in the row");

    // no token left in the row and nothing pending when idle
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_pend_v && (tok_vec == '0)))
        else $error("idle with work in flight");

    // a read goes straight to flush
    a_read_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.mode == MODE_READ)) |=> (r_state == ST_FLUSH && r_pend_v))
        else $error("read word not staged");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_multi_slot_timeout_timer.sv
`timescale 1ns / 1ps

module tb_multi_slot_timeout_timer;
    import mstt_pkg::*;

    localparam int SLOTS        = 4;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 20;    // settle time after the last expected word
    localparam int RANDOM_WORDS = 105;

    // Mode codes above MODE_READ carry no operation
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_word   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_word;

    // Drop all idling while set, for stretches of back-to-back traffic
    bit quiet = 1'b0;

    multi_slot_timeout_timer #(
        .SLOT_COUNT (SLOTS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word)
    );

    // Timer shadow: tracks the counter and the slot table, queues the words
    // each accepted input word must cause, and checks returned words in order.
    class timer_tracker;
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] deadline [SLOTS];
        logic [TIME_W-1:0] period   [SLOTS];
        bit                repeating[SLOTS];
        bit                busy     [SLOTS];
        t_out              awaited[$];
        int                errors;
        int                words_checked;
        int                fired_seen;
        int                full_seen;
        int                inputs_taken;

        function new();
            clock_ms      = '0;
            errors        = 0;
            words_checked = 0;
            fired_seen    = 0;
            full_seen     = 0;
            inputs_taken  = 0;
            for (int i = 0; i < SLOTS; i++) begin
                deadline[i]  = '0;
                period[i]    = '0;
                repeating[i] = 1'b0;
                busy[i]      = 1'b0;
            end
        endfunction

        // Advance the shadow by one accepted input word
        function void note_word(t_in w);
            t_out r;
            int   free_slot;
            int   queued;
            queued = awaited.size();
            inputs_taken++;
            case (w.mode)
                MODE_TICK: begin
                    clock_ms = clock_ms + 1'b1;
                end
                MODE_START: begin
                    free_slot = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (!busy[i] && free_slot < 0) free_slot = i;
                    r      = '0;
                    r.kind = KIND_GRANT;
                    if (free_slot < 0) begin
                        r.no_free_slot = 1'b1;
                    end else begin
                        deadline[free_slot]  = clock_ms + w.delay;
                        period[free_slot]    = w.delay;
                        repeating[free_slot] = w.periodic;
                        busy[free_slot]      = 1'b1;
                        r.slot               = SLOT_W'(free_slot);
                    end
                    awaited.push_back(r);
                end
                MODE_CANCEL: begin
                    if (w.slot_id < SLOTS) busy[w.slot_id] = 1'b0;
                end
                MODE_UPDATE: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (busy[i] && clock_ms >= deadline[i]) begin
                            r      = '0;
                            r.kind = KIND_FIRED;
                            r.slot = SLOT_W'(i);
                            awaited.push_back(r);
                            if (repeating[i]) deadline[i] = clock_ms + period[i];
                            else busy[i] = 1'b0;
                        end
                    end
                end
                MODE_READ: begin
                    r            = '0;
                    r.kind       = KIND_TIME;
                    r.time_value = clock_ms;
                    awaited.push_back(r);
                end
                default: ;
            endcase
            // Flag the final word of this input
            if (awaited.size() > queued) begin
                r      = awaited.pop_back();
                r.last = 1'b1;
                awaited.push_back(r);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_word(t_out got);
            t_out want;
            words_checked++;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
            end else begin
                want = awaited.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("word %0d kind %0d, want %0d",
                                              words_checked, got.kind, want.kind));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("word %0d slot %0d, want %0d",
                                              words_checked, got.slot, want.slot));
                if (got.no_free_slot !== want.no_free_slot)
                    report_mismatch($sformatf("word %0d no_free_slot %b, want %b",
                                              words_checked, got.no_free_slot,
                                              want.no_free_slot));
                if (got.time_value !== want.time_value)
                    report_mismatch($sformatf("word %0d time_value %h, want %h",
                                              words_checked, got.time_value,
                                              want.time_value));
                if (got.last !== want.last)
                    report_mismatch($sformatf("word %0d last %b, want %b",
                                              words_checked, got.last, want.last));
                if (want.kind == KIND_FIRED) fired_seen++;
                if (want.no_free_slot) full_seen++;
            end
        endtask
    endclass

    timer_tracker tracker;

    initial begin
        forever #5 clk = ~clk;
    end

    // Mostly short idle runs, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet) return 0;
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in make_word(logic [2:0] mode, logic [TIME_W-1:0] delay,
                                      logic periodic, logic [SLOT_W-1:0] sid);
        t_in w;
        w.mode     = mode;
        w.delay    = delay;
        w.periodic = periodic;
        w.slot_id  = sid;
        return w;
    endfunction

    // Random word: all fields random, then bias mode and the fields it reads
    function automatic t_in random_word();
        t_in w;
        int  roll;
        w.mode     = 3'($urandom);
        w.delay    = $urandom;
        w.periodic = 1'($urandom);
        w.slot_id  = SLOT_W'($urandom);
        roll       = $urandom_range(0, 99);
        if (roll < 38) begin
            w.mode = MODE_TICK;
        end else if (roll < 58) begin
            w.mode = MODE_START;
            roll   = $urandom_range(0, 99);
            // Keep most delays short so slots expire within the run
            if (roll < 65) w.delay = $urandom_range(0, 12);
            else if (roll < 85) w.delay = $urandom_range(0, 200);
        end else if (roll < 70) begin
            w.mode = MODE_CANCEL;
            if ($urandom_range(0, 9) < 7) w.slot_id = SLOT_W'($urandom_range(0, SLOTS - 1));
        end else if (roll < 90) begin
            w.mode = MODE_UPDATE;
        end else if (roll < 97) begin
            w.mode = MODE_READ;
        end else begin
            w.mode = MODE_SPARE_FIRST + 3'($urandom_range(0, 2));
        end
        return w;
    endfunction

    // Present one input word; return at the edge that accepts it.
    // Valid stays high afterwards so a back-to-back word needs no toggle.
    task automatic push_word(input t_in w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        tracker.note_word(w);
    endtask

    // Receiver: alternate open runs with stall runs
    initial begin : out_staller
        int run;
        @(posedge clk iff rst_n);
        forever begin
            run = $urandom_range(1, 6);
            repeat (run) @(posedge clk);
            run = pick_gap();
            if (run > 0) begin
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check every output word taken at this edge
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) tracker.check_word(out_word);
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
            else idle++;
        end
        $display("[%0t] no word moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int counted;
        t_in w;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, grants up to a full table, expiry, cancel cases,
        // spare modes and a target that wraps past the top of the counter
        push_word(make_word(MODE_READ,   32'd0,          1'b0, 4'd0));
        push_word(make_word(MODE_UPDATE, 32'd0,          1'b0, 4'd0));
        push_word(make_word(MODE_START,  32'd0,          1'b0, 4'd9));
        push_word(make_word(MODE_UPDATE, 32'hFFFF_FFFF,  1'b1, 4'd15));
        push_word(make_word(MODE_START,  32'hFFFF_FFFF,  1'b1, 4'd0));
        push_word(make_word(MODE_START,  32'd2,          1'b1, 4'd5));
        push_word(make_word(MODE_START,  32'd1,          1'b0, 4'd10));
        push_word(make_word(MODE_START,  32'd3,          1'b0, 4'd3));
        push_word(make_word(MODE_START,  32'd5,          1'b1, 4'd1));
        push_word(make_word(MODE_TICK,   32'hA5A5_5A5A,  1'b1, 4'd15));
        push_word(make_word(MODE_UPDATE, 32'd0,          1'b0, 4'd0));
        push_word(make_word(MODE_TICK,   32'h5A5A_A5A5,  1'b0, 4'd0));
        push_word(make_word(MODE_TICK,   32'd0,          1'b1, 4'd7));
        push_word(make_word(MODE_UPDATE, 32'd0,          1'b0, 4'd0));
        push_word(make_word(MODE_CANCEL, 32'd0,          1'b0, 4'd15));
        push_word(make_word(MODE_CANCEL, 32'd0,          1'b0, 4'(SLOTS)));
        push_word(make_word(MODE_CANCEL, 32'd0,          1'b0, 4'd2));
        push_word(make_word(MODE_CANCEL, 32'd0,          1'b0, 4'd0));
        push_word(make_word(MODE_SPARE_FIRST,        32'hFFFF_FFFF, 1'b1, 4'd0));
        push_word(make_word(MODE_SPARE_FIRST + 3'd1, 32'd0,         1'b0, 4'd1));
        push_word(make_word(MODE_SPARE_FIRST + 3'd2, 32'd7,         1'b1, 4'd2));
        push_word(make_word(MODE_START,  32'hFFFF_FFFF,  1'b0, 4'd0));
        push_word(make_word(MODE_UPDATE, 32'd0,          1'b0, 4'd0));
        push_word(make_word(MODE_READ,   32'hFFFF_FFFF,  1'b1, 4'd15));
        push_word(make_word(MODE_CANCEL, 32'd0,          1'b0, 4'd1));

        // Random traffic
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            quiet = ((counted / 20) % 3) == 2;
            w     = random_word();
            push_word(w);
            counted++;
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        // Drain every expected word, then let trailing work settle
        while (tracker.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Took %0d input words, checked %0d output words.",
                 tracker.inputs_taken, tracker.words_checked);
        $display("Saw %0d fired slots and %0d full-table replies; %0d mismatches.",
                 tracker.fired_seen, tracker.full_seen, tracker.errors);
        if (tracker.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
